/* hdl/pn3d_pkg.sv */
// Shared constants and types for the 3-D gradient noise block.
`default_nettype none
package pn3d_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// Generator constants, split into 24-bit halves for the stepped multiply.
	localparam logic [47:0] LCG_MUL = 48'h0005_DEEC_E66D;
	localparam logic [23:0] LCG_ML  = 24'hEC_E66D;
	localparam logic [23:0] LCG_MH  = 24'h00_05DE;
	localparam logic [47:0] LCG_ADD = 48'h0000_0000_000B;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int FIFO_DEPTH = 32;
	localparam int FIFO_AW = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEFF_X,
		REG_COEFF_Y,
		REG_COEFF_Z,
		REG_COEFF_OFFSET
	} cfg_reg_t;

endpackage
`default_nettype wire

/* hdl/perlin_noise_3d.sv */
// Top level of the 3-D gradient noise block: hash, cell chains, blend and output queue.
// Throughput: one word per cycle while in_ready stays high.
// Rate is set by the fully pipelined generator cells (two multiply stages per step).
// Results queue in a 32-word buffer; in_ready drops only when 32 words are owed.
// Reset clears the coefficients to zero, the valid pipe and the queue pointers.
// Pipeline payload registers carry no reset.
`default_nettype none
module perlin_noise_3d #(
	parameter int FRAC_BITS = pn3d_pkg::FRAC_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [pn3d_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pn3d_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [31:0]                pos_x,
	input  wire logic signed [31:0]                pos_y,
	input  wire logic signed [31:0]                pos_z,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [18:0]                     noise_value
);
	import pn3d_pkg::*;

	localparam int ACC_W = FRAC_BITS + 19;
	localparam int DOT_W = FRAC_BITS + 3;
	localparam int PIPE_STAGES = 21;
	// weights must meet the blend stages: x at stage 15, y at 17, z at 19
	localparam int WX_DLY = 11;
	localparam int WY_DLY = 13;
	localparam int WZ_DLY = 15;

	// Configuration registers
	logic [31:0] coeff_x_q, coeff_y_q, coeff_z_q, coeff_off_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_x_q <= '0;
			coeff_y_q <= '0;
			coeff_z_q <= '0;
			coeff_off_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_COEFF_X:      coeff_x_q <= cfg_data;
				REG_COEFF_Y:      coeff_y_q <= cfg_data;
				REG_COEFF_Z:      coeff_z_q <= cfg_data;
				REG_COEFF_OFFSET: coeff_off_q <= cfg_data;
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

	// Handshake and credit count: every accepted word owns a queue slot until taken
	logic in_fire, out_fire;
	logic [FIFO_AW:0] count_q;
	logic [PIPE_STAGES:1] vld_q;

	assign in_ready = (count_q < (FIFO_AW+1)'(FIFO_DEPTH));
	assign in_fire = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_q <= '0;
		end else begin
			count_q <= count_q + (FIFO_AW+1)'(in_fire) - (FIFO_AW+1)'(out_fire);
			vld_q <= {vld_q[PIPE_STAGES-1:1], in_fire};
		end
	end

	// Stage 1: coordinate products, low 32 bits only (hash wraps)
	logic signed [47:0] mx, my, mz;
	logic [31:0] px_s1, py_s1, pz_s1;
	logic [2:0][15:0] u_s1, u_s2, u_s3;

	assign mx = $signed(pos_x[31:16]) * $signed(coeff_x_q);
	assign my = $signed(pos_y[31:16]) * $signed(coeff_y_q);
	assign mz = $signed(pos_z[31:16]) * $signed(coeff_z_q);

	// Stage 2: partial hash sums, xy for four corners and z plus offset for two
	logic [31:0] sxy_s2 [4];
	logic [31:0] zo_s2 [2];

	always_ff @(posedge clk) begin
		px_s1 <= mx[31:0];
		py_s1 <= my[31:0];
		pz_s1 <= mz[31:0];
		u_s1 <= {pos_z[15:0], pos_y[15:0], pos_x[15:0]};

		sxy_s2[0] <= px_s1 + py_s1;
		sxy_s2[1] <= px_s1 + coeff_x_q + py_s1;
		sxy_s2[2] <= px_s1 + py_s1 + coeff_y_q;
		sxy_s2[3] <= px_s1 + coeff_x_q + py_s1 + coeff_y_q;
		zo_s2[0] <= pz_s1 + coeff_off_q;
		zo_s2[1] <= pz_s1 + coeff_z_q + coeff_off_q;
		u_s2 <= u_s1;

		u_s3 <= u_s2;
	end

	// Stage 3: full hash, sign-extended and scrambled into the seed
	logic [31:0] hsum [8];
	logic [47:0] seed_c3 [8];
	always_comb begin
		for (int c = 0; c < 8; c++) begin
			hsum[c] = sxy_s2[c%4] + zo_s2[c/4];
			seed_c3[c] = {{16{hsum[c][31]}}, hsum[c]} ^ LCG_MUL;
		end
	end

	logic [47:0] seed_r3 [8];
	always_ff @(posedge clk) begin
		for (int c = 0; c < 8; c++) begin
			seed_r3[c] <= seed_c3[c];
		end
	end

	// Corner lanes: a chain of three cells each, one per gradient axis
	logic signed [DOT_W-1:0] dot [8];

	for (genvar c = 0; c < 8; c++) begin : g_lane
		logic [47:0] sd [4];
		logic signed [ACC_W-1:0] acc [4];
		logic [2:0][15:0] uu [4];

		assign sd[0] = seed_r3[c];
		assign acc[0] = '0;
		assign uu[0] = u_s3;

		for (genvar a = 0; a < 3; a++) begin : g_cell
			pn3d_grad_cell #(
				.FRAC_BITS(FRAC_BITS),
				.AXIS(a),
				.HI(((c >> a) & 1) == 1)
			) u_cell (
				.clk(clk),
				.seed_in(sd[a]),
				.acc_in(acc[a]),
				.u_in(uu[a]),
				.seed_out(sd[a+1]),
				.acc_out(acc[a+1]),
				.u_out(uu[a+1])
			);
		end

		// floor to F fraction bits; the chain's trailing seed and offsets go unused
		assign dot[c] = DOT_W'(acc[3] >>> 16);
		logic unused_lane;
		assign unused_lane = ^{sd[3], uu[3]};
	end

	// Fade weights, aligned to the blend stages
	logic [FRAC_BITS:0] wx, wy, wz;

	pn3d_weight #(.FRAC_BITS(FRAC_BITS), .DELAY(WX_DLY)) u_wx (
		.clk(clk), .u(pos_x[15:0]), .w(wx));
	pn3d_weight #(.FRAC_BITS(FRAC_BITS), .DELAY(WY_DLY)) u_wy (
		.clk(clk), .u(pos_y[15:0]), .w(wy));
	pn3d_weight #(.FRAC_BITS(FRAC_BITS), .DELAY(WZ_DLY)) u_wz (
		.clk(clk), .u(pos_z[15:0]), .w(wz));

	// Trilinear blend: x pairs, then y, then z
	logic signed [DOT_W-1:0] bx [4];
	logic signed [DOT_W-1:0] by [2];
	logic signed [DOT_W-1:0] bz;

	for (genvar m = 0; m < 4; m++) begin : g_bx
		pn3d_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
			.clk(clk), .a(dot[2*m]), .b(dot[2*m+1]), .w(wx), .r(bx[m]));
	end
	for (genvar n = 0; n < 2; n++) begin : g_by
		pn3d_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
			.clk(clk), .a(bx[2*n]), .b(bx[2*n+1]), .w(wy), .r(by[n]));
	end
	pn3d_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_z (
		.clk(clk), .a(by[0]), .b(by[1]), .w(wz), .r(bz));

	// Convert to Q.16
	logic signed [18:0] conv;
	generate
		if (FRAC_BITS >= 16) begin : g_cdn
			assign conv = 19'(bz >>> (FRAC_BITS - 16));
		end else begin : g_cup
			assign conv = 19'(bz) <<< (16 - FRAC_BITS);
		end
	endgenerate

	// Output queue: write when a word leaves the last stage, read on out_fire
	logic [18:0] fifo_q [FIFO_DEPTH];
	logic [FIFO_AW:0] wr_ptr_q, rd_ptr_q;
	logic fifo_we;
	logic [FIFO_AW:0] fifo_level;

	assign fifo_we = vld_q[PIPE_STAGES];
	assign fifo_level = wr_ptr_q - rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (fifo_we) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (out_fire) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_we) fifo_q[wr_ptr_q[FIFO_AW-1:0]] <= conv;
	end

	assign out_valid = (wr_ptr_q != rd_ptr_q);
	assign noise_value = $signed(fifo_q[rd_ptr_q[FIFO_AW-1:0]]);

	// Credits cover every stored word plus every word in flight
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("credit count above queue depth");

	a_level_le_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_level <= count_q)
		else $error("queue holds more words than credits taken");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_we |-> (fifo_level < (FIFO_AW+1)'(FIFO_DEPTH)))
		else $error("queue written while full");

	a_valid_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("result shown with no word owed");
endmodule
`default_nettype wire

/* hdl/pn3d_grad_cell.sv */
// One gradient component cell: two generator steps and one multiply-accumulate.
`default_nettype none
module pn3d_grad_cell #(
	parameter int FRAC_BITS = 16,
	parameter int AXIS = 0,
	parameter bit HI = 1'b0
) (
	input  wire logic                        clk,
	input  wire logic [47:0]                 seed_in,
	input  wire logic signed [FRAC_BITS+18:0] acc_in,
	input  wire logic [2:0][15:0]            u_in,
	output logic [47:0]                      seed_out,
	output logic signed [FRAC_BITS+18:0]     acc_out,
	output logic [2:0][15:0]                 u_out
);
	import pn3d_pkg::*;

	localparam int ACC_W = FRAC_BITS + 19;
	localparam int PROD_W = FRAC_BITS + 18;

	logic [47:0] lo_a, lo_b;
	logic [23:0] hi_a, hi_b;
	logic [47:0] ppl_s1, seed_a_s2, ppl_s3, seed_b_s4;
	logic [23:0] pph_s1, pph_s3;
	logic signed [ACC_W-1:0] acc_s1, acc_s2, acc_s3, acc_s4;
	logic [2:0][15:0] u_s1, u_s2, u_s3, u_s4;
	logic [FRAC_BITS-1:0] g;
	logic signed [16:0] d;
	logic signed [PROD_W-1:0] prod, prod_s3;

	// Partial products of s * M mod 2^48 (high cross terms only need 24 bits).
	assign lo_a = seed_in[23:0] * LCG_ML;
	assign hi_a = seed_in[23:0] * LCG_MH + seed_in[47:24] * LCG_ML;
	assign lo_b = seed_a_s2[23:0] * LCG_ML;
	assign hi_b = seed_a_s2[23:0] * LCG_MH + seed_a_s2[47:24] * LCG_ML;

	assign g = seed_a_s2[47 -: FRAC_BITS];
	assign d = $signed({HI, u_s2[AXIS]});
	assign prod = $signed({1'b0, g}) * d;

	always_ff @(posedge clk) begin
		ppl_s1 <= lo_a;
		pph_s1 <= hi_a;
		acc_s1 <= acc_in;
		u_s1 <= u_in;

		seed_a_s2 <= ppl_s1 + {pph_s1, 24'h000000} + LCG_ADD;
		acc_s2 <= acc_s1;
		u_s2 <= u_s1;

		ppl_s3 <= lo_b;
		pph_s3 <= hi_b;
		prod_s3 <= prod;
		acc_s3 <= acc_s2;
		u_s3 <= u_s2;

		seed_b_s4 <= ppl_s3 + {pph_s3, 24'h000000} + LCG_ADD;
		acc_s4 <= acc_s3 + ACC_W'(prod_s3);
		u_s4 <= u_s3;
	end

	assign seed_out = seed_b_s4;
	assign acc_out = acc_s4;
	assign u_out = u_s4;
endmodule
`default_nettype wire

/* hdl/pn3d_weight.sv */
// Quintic fade weight pipeline with an aligning delay line.
`default_nettype none
module pn3d_weight #(
	parameter int FRAC_BITS = 16,
	parameter int DELAY = 1
) (
	input  wire logic              clk,
	input  wire logic [15:0]       u,
	output logic [FRAC_BITS:0]     w
);
	import pn3d_pkg::*;

	localparam int F = FRAC_BITS;
	localparam logic signed [F+4:0] C15 = (F+5)'(15) <<< F;
	localparam logic signed [F+5:0] C10 = (F+6)'(10) <<< F;

	logic [F-1:0] t, t_s1, t_s2;
	logic signed [F+4:0] pm_s1;
	logic [2*F-1:0] t2_s1, q1t;
	logic signed [2*F+5:0] pt;
	logic signed [F+5:0] pf;
	logic [F+3:0] p_s2, p_s3;
	logic [F-1:0] q1_s2, q2_s3;
	logic [2*F+3:0] qp;
	logic [F:0] w_s4;
	logic [F:0] dly_q [DELAY];

	generate
		if (F >= 16) begin : g_up
			assign t = F'(u) << (F - 16);
		end else begin : g_dn
			assign t = F'(u >> (16 - F));
		end
	endgenerate

	assign pt = pm_s1 * $signed({1'b0, t_s1});
	assign pf = (F+6)'(pt >>> F) + C10;
	assign q1t = q1_s2 * t_s2;
	assign qp = q2_s3 * p_s3;

	always_ff @(posedge clk) begin
		// 6t - 15: build 4t + 2t in a wide word, then offset
		pm_s1 <= (F+5)'($signed({3'b000, t, 2'b00}) + $signed({4'b0000, t, 1'b0}))
			- C15;
		t2_s1 <= t * t;
		t_s1 <= t;

		p_s2 <= pf[F+3:0];
		q1_s2 <= t2_s1[2*F-1:F];
		t_s2 <= t_s1;

		q2_s3 <= q1t[2*F-1:F];
		p_s3 <= p_s2;

		w_s4 <= qp[2*F:F];
	end

	always_ff @(posedge clk) begin
		dly_q[0] <= w_s4;
		for (int i = 1; i < DELAY; i++) begin
			dly_q[i] <= dly_q[i-1];
		end
	end

	assign w = dly_q[DELAY-1];
endmodule
`default_nettype wire

/* hdl/pn3d_lerp.sv */
// Two-stage linear blend a + floor(w * (b - a) / 2^F).
`default_nettype none
module pn3d_lerp #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic signed [FRAC_BITS+2:0] a,
	input  wire logic signed [FRAC_BITS+2:0] b,
	input  wire logic [FRAC_BITS:0]          w,
	output logic signed [FRAC_BITS+2:0]      r
);
	import pn3d_pkg::*;

	localparam int DOT_W = FRAC_BITS + 3;
	localparam int PRD_W = 2 * FRAC_BITS + 6;

	logic signed [DOT_W:0] diff;
	logic signed [PRD_W-1:0] prod, prod_s1;
	logic signed [DOT_W-1:0] a_s1, r_s2;

	assign diff = (DOT_W+1)'(b) - (DOT_W+1)'(a);
	assign prod = $signed({1'b0, w}) * diff;

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		a_s1 <= a;
		r_s2 <= a_s1 + DOT_W'(prod_s1 >>> FRAC_BITS);
	end

	assign r = r_s2;
endmodule
`default_nettype wire
